// ----- rtl/ringdq_pkg.sv -----
// Shared types and codes for the ring deque: command kinds, result status,
// back-end operation codes and the control word passed from front to back.
// No dependencies.
package ringdq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CMDQ_DEPTH     = 2;

	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;
	localparam int FIELD_W  = 32;
	localparam int OCC_W    = 7;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TAKE_FRONT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TAKE_BACK  = 3'd3;

	typedef logic [OCC_W-1:0] occ_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_SWAP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
		occ_t    occupancy;
	} cmd_ctl_t;

endpackage

// ----- rtl/ringdq_cmdq.sv -----
// Two-entry command queue between the front and back ends.
// Generic over the packed command width; depends on ringdq_pkg.
module ringdq_cmdq #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd,
	output logic         valid,
	output logic [W-1:0] rd_data
);
	import ringdq_pkg::*;

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	logic [W-1:0]     slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/ringdq_front.sv -----
// Front end: accepts commands, tracks head, tail and count, and turns each
// item into a resolved memory operation with its status. Uses ringdq_pkg.
module ringdq_front #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [ringdq_pkg::KIND_W-1:0] kind,
	input  logic signed [ringdq_pkg::FIELD_W-1:0] value,
	input  logic                          cmdq_full,
	output logic                          cmd_wr,
	output ringdq_pkg::cmd_ctl_t          ctl,
	output logic [$clog2(DEPTH)-1:0]      addr_a,
	output logic [$clog2(DEPTH)-1:0]      addr_b,
	output logic [DATA_WIDTH-1:0]         word
);
	import ringdq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [PW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic          is_full, is_empty;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
	endfunction

	assign full     = cmdq_full;
	assign cmd_wr   = push && !cmdq_full;
	assign is_full  = (count_q >= CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign word     = DATA_WIDTH'(value);

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		ctl.op     = OP_NOP;
		ctl.status = ST_OK;
		addr_a     = head_q;
		addr_b     = ring_prev(tail_q);
		case (kind)
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					ctl.status = ST_FULL;
				end else begin
					head_d  = ring_prev(head_q);
					addr_a  = ring_prev(head_q);
					ctl.op  = OP_WRITE;
					count_d = count_q + 1'b1;
				end
			end
			KIND_PUSH_BACK: begin
				if (is_full) begin
					ctl.status = ST_FULL;
				end else begin
					addr_a  = tail_q;
					tail_d  = ring_next(tail_q);
					ctl.op  = OP_WRITE;
					count_d = count_q + 1'b1;
				end
			end
			KIND_TAKE_FRONT: begin
				if (is_empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					head_d  = ring_next(head_q);
					ctl.op  = OP_READ;
					count_d = count_q - 1'b1;
				end
			end
			KIND_TAKE_BACK: begin
				if (is_empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					tail_d  = ring_prev(tail_q);
					addr_a  = ring_prev(tail_q);
					ctl.op  = OP_READ;
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				// swap ends; unused kind codes behave the same way
				if (count_q >= CW'(2)) begin
					ctl.op = OP_SWAP;
				end
			end
		endcase
		ctl.occupancy = occ_t'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd_wr) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

endmodule

// ----- rtl/ringdq_back.sv -----
// Back end: holds the entry store and carries out resolved commands,
// then presents one result per command in an output register. Uses ringdq_pkg.
module ringdq_back #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_pop,
	input  ringdq_pkg::cmd_ctl_t             ctl,
	input  logic [$clog2(DEPTH)-1:0]         addr_a,
	input  logic [$clog2(DEPTH)-1:0]         addr_b,
	input  logic [DATA_WIDTH-1:0]            word,
	output logic                             empty,
	input  logic                             pop,
	output logic [ringdq_pkg::STATUS_W-1:0]  status,
	output logic signed [ringdq_pkg::FIELD_W-1:0] data,
	output logic [ringdq_pkg::OCC_W-1:0]     occupancy
);
	import ringdq_pkg::*;

	localparam int PW = $clog2(DEPTH);

	typedef enum logic [1:0] {
		S_ISSUE,
		S_READ,
		S_WR2
	} state_t;

	state_t state_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;

	cmd_ctl_t      ctl_q;
	logic [PW-1:0] addr_a_q, addr_b_q;

	logic                out_valid_q;
	status_t             status_q;
	logic signed [FIELD_W-1:0] data_q;
	occ_t                occ_q;

	logic                  out_free;
	logic                  start, do_read;
	logic                  we;
	logic [PW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;

	assign out_free = !out_valid_q || pop;
	assign start    = (state_q == S_ISSUE) && cmd_valid && out_free;
	assign cmd_pop  = start;
	assign do_read  = start && (ctl.op == OP_READ || ctl.op == OP_SWAP);

	// single write port: pushes at issue, swap writes in its last two steps
	always_comb begin
		we    = 1'b0;
		waddr = addr_a;
		wdata = word;
		case (state_q)
			S_ISSUE: begin
				we = start && (ctl.op == OP_WRITE);
			end
			S_READ: begin
				we    = (ctl_q.op == OP_SWAP);
				waddr = addr_a_q;
				wdata = rd_b_q;
			end
			S_WR2: begin
				we    = 1'b1;
				waddr = addr_b_q;
				wdata = rd_a_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (do_read) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ISSUE;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			data_q      <= '0;
			occ_q       <= '0;
			ctl_q       <= '0;
			addr_a_q    <= '0;
			addr_b_q    <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_ISSUE: begin
					if (start) begin
						ctl_q    <= ctl;
						addr_a_q <= addr_a;
						addr_b_q <= addr_b;
						if (do_read) begin
							state_q <= S_READ;
						end else begin
							out_valid_q <= 1'b1;
							status_q    <= ctl.status;
							data_q      <= '0;
							occ_q       <= ctl.occupancy;
						end
					end
				end
				S_READ: begin
					if (ctl_q.op == OP_SWAP) begin
						state_q <= S_WR2;
					end else begin
						state_q     <= S_ISSUE;
						out_valid_q <= 1'b1;
						status_q    <= ctl_q.status;
						data_q      <= FIELD_W'(signed'(rd_a_q));
						occ_q       <= ctl_q.occupancy;
					end
				end
				S_WR2: begin
					state_q     <= S_ISSUE;
					out_valid_q <= 1'b1;
					status_q    <= ctl_q.status;
					data_q      <= '0;
					occ_q       <= ctl_q.occupancy;
				end
				default: begin
					state_q <= S_ISSUE;
				end
			endcase
		end
	end

	assign empty     = !out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign occupancy = occ_q;

endmodule

// ----- rtl/ring_deque_with_end_swap_core.sv -----
// Ring deque with end swap: command queue in, result queue out.
// Input side: present kind/value with push; the item is taken when full is low.
// Kinds: push front, push back, take front, take back, swap ends (codes 5-7
// also swap). Every item yields exactly one result, in order, with a status
// (ok, take on empty, push dropped when full), the word taken (zero otherwise)
// and the occupancy after the command.
// Output side: a result is valid while empty is low; pop takes it.
// A command is accepted into the command queue; its result is registered at
// issue for pushes and failed or no-op commands, after the store read for
// takes, and after both write-backs for swaps. The single write port and
// registered reads hold off the next command until a take or swap is done.
// A two-entry command queue lets the front keep accepting while the back is
// busy or a result waits; when pop is held low the back stops after one
// finished result and the command queue fills, raising full.
// Reset (arst_n low) empties the deque and both queues; store contents are
// not cleared and are never read before being written.
// Depends on ringdq_pkg, ringdq_front, ringdq_cmdq, ringdq_back.
module ring_deque_with_end_swap_core #(
	parameter int DEPTH      = ringdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ringdq_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [ringdq_pkg::KIND_W-1:0]         kind,
	input  logic signed [ringdq_pkg::FIELD_W-1:0] value,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [ringdq_pkg::STATUS_W-1:0]       status,
	output logic signed [ringdq_pkg::FIELD_W-1:0] data,
	output logic [ringdq_pkg::OCC_W-1:0]          occupancy
);
	import ringdq_pkg::*;

	localparam int PW  = $clog2(DEPTH);
	localparam int CMD_W = $bits(cmd_ctl_t) + 2 * PW + DATA_WIDTH;

	logic                  cmdq_full, cmd_wr, cmd_valid, cmd_pop;
	cmd_ctl_t              f_ctl, b_ctl;
	logic [PW-1:0]         f_addr_a, f_addr_b, b_addr_a, b_addr_b;
	logic [DATA_WIDTH-1:0] f_word, b_word;
	logic [CMD_W-1:0]      cmd_in, cmd_out;

	ringdq_front #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.value     (value),
		.cmdq_full (cmdq_full),
		.cmd_wr    (cmd_wr),
		.ctl       (f_ctl),
		.addr_a    (f_addr_a),
		.addr_b    (f_addr_b),
		.word      (f_word)
	);

	assign cmd_in = {f_ctl, f_addr_a, f_addr_b, f_word};

	ringdq_cmdq #(
		.W (CMD_W)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_wr),
		.wr_data (cmd_in),
		.full    (cmdq_full),
		.rd      (cmd_pop),
		.valid   (cmd_valid),
		.rd_data (cmd_out)
	);

	assign {b_ctl, b_addr_a, b_addr_b, b_word} = cmd_out;

	ringdq_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.ctl       (b_ctl),
		.addr_a    (b_addr_a),
		.addr_b    (b_addr_b),
		.word      (b_word),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.data      (data),
		.occupancy (occupancy)
	);

`ifndef SYNTHESIS
	// failed commands never carry a word
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (data == '0))
	else $error("failed command returned nonzero data");

	// a take on empty can only report an empty deque
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_EMPTY) |-> (occupancy == '0))
	else $error("empty status with nonzero occupancy");

	// a dropped push reports a full deque
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)))
	else $error("full status with occupancy below capacity");

	// back end only pulls commands that are in the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
	else $error("command queue underflow");
`endif

endmodule
